FILE: design/fbpa_pkg.sv
// Shared constants and types for the fixed block pool allocator.
`default_nettype none

package fbpa_pkg;

	localparam int NUM_BLOCKS_DEF   = 256;
	localparam int BLOCK_STRIDE_DEF = 64;

	localparam int OFFSET_W = 16;
	localparam int STATUS_W = 3;

	// Request opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE     = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_MISALIGN  = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOC = 3'd4;

	// Decoded free offset: range and alignment flags plus the block index.
	typedef struct packed {
		logic                range_err;
		logic                misalign;
		logic [OFFSET_W-1:0] quot;
	} offdec_t;

endpackage

`default_nettype wire

FILE: design/fixed_block_pool_allocator_unit.sv
// Top level of the fixed block pool allocator: free-list control around the link RAM.
//
//  channel   ports                              direction  handshake
//  --------  ---------------------------------  ---------  ------------------------------
//  request   start, busy, op, block_offset      in         taken when start && !busy
//  result    done, status, result_offset        out        one-cycle strobe, no stall
//
// After reset the block sweeps the link RAM once, writing entry i with i+1,
// with busy held high.
// An allocate reads the link of the head block, then links that block to
// itself and advances the head; an allocate on an empty pool is answered
// without a RAM access. A free passes through the stages of the offset decoder
// for the stride division, then the link RAM read, then the check and write
// back. Offset errors on a free are answered once the decoder is through.
// Items are handled one at a time; busy is high until the last RAM access of
// the item is done. The receiver cannot stall, so done is a plain strobe.
`default_nettype none

module fixed_block_pool_allocator_unit #(
	parameter int NUM_BLOCKS   = fbpa_pkg::NUM_BLOCKS_DEF,
	parameter int BLOCK_STRIDE = fbpa_pkg::BLOCK_STRIDE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          op,
	input  wire logic [fbpa_pkg::OFFSET_W-1:0] block_offset,
	output logic                               done,
	output logic      [fbpa_pkg::STATUS_W-1:0] status,
	output logic      [fbpa_pkg::OFFSET_W-1:0] result_offset
);

	localparam int OW     = fbpa_pkg::OFFSET_W;
	localparam int SW     = fbpa_pkg::STATUS_W;
	localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int LINK_W = $clog2(NUM_BLOCKS + 1);

	localparam logic [LINK_W-1:0] LINK_END = LINK_W'(NUM_BLOCKS);
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_BLOCKS - 1);
	localparam logic [31:0]       STRIDE32 = 32'(BLOCK_STRIDE);

	localparam logic [2:0] ST_INIT  = 3'd0;  // link RAM sweep after reset
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_AREAD = 3'd2;  // allocate: head link arriving
	localparam logic [2:0] ST_FDEC  = 3'd3;  // free: decoder first stage
	localparam logic [2:0] ST_FCHK  = 3'd4;  // free: decoded, issue link read
	localparam logic [2:0] ST_FREAD = 3'd5;  // free: link arriving, check it

	logic [2:0]        state_q;
	logic [2:0]        state_next;
	logic [IDX_W-1:0]  init_cnt_q;
	logic [LINK_W-1:0] head_q;
	logic [LINK_W-1:0] head_next;
	logic [IDX_W-1:0]  blk_q;
	logic [OW-1:0]     alloc_off_q;
	logic              done_q;
	logic [SW-1:0]     status_q;
	logic [OW-1:0]     result_q;

	logic              accept;
	logic [IDX_W-1:0]  head_idx;
	logic [IDX_W-1:0]  dec_blk;
	logic [31:0]       head_prod;
	logic              free_ok;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_addr;
	logic [LINK_W-1:0] ram_wdata;
	logic [LINK_W-1:0] ram_rdata;

	logic              res_valid;
	logic [SW-1:0]     res_status;
	logic [OW-1:0]     res_offset;

	fbpa_pkg::offdec_t dec;

	fbpa_ram #(
		.WIDTH (LINK_W),
		.DEPTH (NUM_BLOCKS)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Offset is sampled every cycle; state timing picks the stage that matters.
	fbpa_offdec #(
		.NUM_BLOCKS   (NUM_BLOCKS),
		.BLOCK_STRIDE (BLOCK_STRIDE)
	) u_offdec (
		.clk    (clk),
		.offset (block_offset),
		.dec    (dec)
	);

	assign busy      = state_q != ST_IDLE;
	assign accept    = start && !busy;
	assign head_idx  = head_q[IDX_W-1:0];
	assign dec_blk   = dec.quot[IDX_W-1:0];
	assign head_prod = 32'(head_idx) * STRIDE32;
	// A block is allocated exactly when its link points at itself
	assign free_ok   = ram_rdata == LINK_W'(blk_q);

	// Link RAM port: sweep, read the head, write back, or check a freed block
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = head_idx;
		ram_wdata = head_q;
		case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_addr  = init_cnt_q;
				ram_wdata = LINK_W'(init_cnt_q) + LINK_W'(1);
			end
			ST_AREAD: begin
				// mark the popped block allocated by linking it to itself
				ram_we    = 1'b1;
				ram_addr  = head_idx;
				ram_wdata = head_q;
			end
			ST_FCHK: begin
				ram_addr = dec_blk;
			end
			ST_FREAD: begin
				// push: the freed block links to the old head
				ram_we    = free_ok;
				ram_addr  = blk_q;
				ram_wdata = head_q;
			end
			default: begin
				ram_addr = head_idx;
			end
		endcase
	end

	// Next state, head update and the result of the cycle
	always_comb begin
		state_next = state_q;
		head_next  = head_q;
		res_valid  = 1'b0;
		res_status = fbpa_pkg::STATUS_OK;
		res_offset = '0;
		case (state_q)
			ST_INIT: begin
				if (init_cnt_q == LAST_IDX) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (op == fbpa_pkg::OP_ALLOC) begin
						if (head_q >= LINK_END) begin
							res_valid  = 1'b1;
							res_status = fbpa_pkg::STATUS_EXHAUSTED;
						end else begin
							state_next = ST_AREAD;
						end
					end else begin
						state_next = ST_FDEC;
					end
				end
			end
			ST_AREAD: begin
				head_next  = ram_rdata;
				res_valid  = 1'b1;
				res_offset = alloc_off_q;
				state_next = ST_IDLE;
			end
			ST_FDEC: begin
				state_next = ST_FCHK;
			end
			ST_FCHK: begin
				// range test takes priority over alignment
				if (dec.range_err) begin
					res_valid  = 1'b1;
					res_status = fbpa_pkg::STATUS_RANGE;
					state_next = ST_IDLE;
				end else if (dec.misalign) begin
					res_valid  = 1'b1;
					res_status = fbpa_pkg::STATUS_MISALIGN;
					state_next = ST_IDLE;
				end else begin
					state_next = ST_FREAD;
				end
			end
			ST_FREAD: begin
				res_valid  = 1'b1;
				state_next = ST_IDLE;
				if (free_ok) begin
					head_next = LINK_W'(blk_q);
				end else begin
					res_status = fbpa_pkg::STATUS_NOT_ALLOC;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			init_cnt_q <= '0;
			head_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_next;
			head_q  <= head_next;
			done_q  <= res_valid;
			if (state_q == ST_INIT) begin
				init_cnt_q <= init_cnt_q + IDX_W'(1);
			end
		end
	end

	// Payload registers: hold the block under work and the result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			alloc_off_q <= head_prod[OW-1:0];
		end
		if (state_q == ST_FCHK) begin
			blk_q <= dec_blk;
		end
		status_q <= res_status;
		result_q <= res_offset;
	end

	assign done          = done_q;
	assign status        = status_q;
	assign result_offset = result_q;

endmodule

`default_nettype wire

FILE: design/fbpa_ram.sv
// Generic single-port synchronous RAM with registered read data.
`default_nettype none

module fbpa_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire logic [WIDTH-1:0]                     wdata,
	output logic      [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

FILE: design/fbpa_offdec.sv
// Two-stage offset decoder: divides a byte offset by the block stride.
`default_nettype none

module fbpa_offdec #(
	parameter int NUM_BLOCKS   = fbpa_pkg::NUM_BLOCKS_DEF,
	parameter int BLOCK_STRIDE = fbpa_pkg::BLOCK_STRIDE_DEF
) (
	input  wire logic                          clk,
	input  wire logic [fbpa_pkg::OFFSET_W-1:0] offset,
	output fbpa_pkg::offdec_t                  dec
);

	localparam int OW = fbpa_pkg::OFFSET_W;
	// floor(2^31 / stride): the estimate is the true quotient or one below
	localparam logic [31:0] RECIP    = 32'((64'd1 << 31) / BLOCK_STRIDE);
	localparam logic [31:0] STRIDE32 = 32'(BLOCK_STRIDE);
	localparam logic [31:0] LAST_OFF = 32'((NUM_BLOCKS - 1) * BLOCK_STRIDE);

	logic [OW-1:0] off_s1;
	logic [OW-1:0] q0_s1;
	logic [47:0]   recip_prod;
	logic [31:0]   back_prod;
	logic [31:0]   rem0;
	logic          corr;
	fbpa_pkg::offdec_t dec_next;
	fbpa_pkg::offdec_t dec_s2;

	assign recip_prod = 48'(offset) * 48'(RECIP);

	always_ff @(posedge clk) begin
		off_s1 <= offset;
		q0_s1  <= recip_prod[46:31];
	end

	// Correct the estimate once; the remainder stays below twice the stride.
	always_comb begin
		back_prod          = 32'(q0_s1) * STRIDE32;
		rem0               = 32'(off_s1) - back_prod;
		corr               = rem0 >= STRIDE32;
		dec_next.range_err = 32'(off_s1) > LAST_OFF;
		dec_next.misalign  = corr ? ((rem0 - STRIDE32) != 32'd0) : (rem0 != 32'd0);
		dec_next.quot      = q0_s1 + OW'(corr);
	end

	always_ff @(posedge clk) begin
		dec_s2 <= dec_next;
	end

	assign dec = dec_s2;

endmodule

`default_nettype wire
